// ===== src/tcw_pkg.sv =====
// Shared constants and types of the text console writer.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [15:0] BLANK_CELL   = 16'h0020;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  ATTR_RESET   = 8'h06;

    // Register index of text_attribute, taken from paddr[2].
    localparam logic CFG_ATTR_IDX = 1'b0;

    typedef enum logic [1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

endpackage

// ===== src/text_console_writer.sv =====
// Text console engine: screen memory, cursor, scroll and clear sequencing.
//
//  Channel  Direction  Ports                         Contents
//  s_       in         s_tvalid s_tready s_tdata     char_code, cell_index; s_tuser = action
//  m_       out        m_tvalid m_tready m_tdata     cursor_column, cursor_row, did_scroll,
//                                                    cell_data
//  apb      in         psel penable pwrite paddr ..  text_attribute at byte address 0
//
// A put without scroll and an unused action are answered straight from ST_IDLE; a read
// goes through ST_READ (one screen memory read). A scroll or a clear sweeps the screen
// memory once, one cell per cycle on its single write port.
// After reset a clearing pass blanks the screen; no request is taken meanwhile.
// A new request is taken only while the result register is empty or being emptied
// in the same cycle.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] action
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [6:0] cursor_column, [11:7] cursor_row,
                                   // [12] did_scroll, [28:13] cell_data, rest zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int UPPER = (ROWS - 1) * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int IW    = (CW > 11) ? CW : 11;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [AW-1:0]     cnt_reg;
    logic              pend_reg;
    logic              pend_blank_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic              copy_reg;
    logic              report_reg;
    logic              scroll_reg;
    logic              rng_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [7:0]        attr_reg;
    logic              m_tvalid_reg;
    logic [6:0]        out_col_reg;
    logic [4:0]        out_row_reg;
    logic              out_scroll_reg;
    logic [15:0]       out_data_reg;

    logic              s_fire;
    tcw_pkg::action_t  in_action;
    logic [7:0]        in_char;
    logic [10:0]       in_idx;
    logic              in_rng;
    logic              is_put;
    logic              is_nl;
    logic              wrap;
    logic              last_row;
    logic              need_scroll;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [AW-1:0]     cur_pos;
    logic              sweep_copy;
    logic              cfg_wr;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [15:0]       ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [15:0]       ram_rdata;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign in_action = tcw_pkg::action_t'(s_tuser);
    assign in_char   = s_tdata[7:0];
    assign in_idx    = s_tdata[18:8];
    assign in_rng    = IW'(in_idx) < IW'(CELLS);

    assign is_put      = (in_action == tcw_pkg::ACT_PUT);
    assign is_nl       = (in_char == tcw_pkg::NEWLINE_CODE);
    assign wrap        = is_nl || (col_reg == COL_W'(COLUMNS - 1));
    assign last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign need_scroll = is_put && wrap && last_row;

    always_comb begin
        if (wrap) begin
            col_next = '0;
            row_next = last_row ? ROW_W'(ROWS - 1) : ROW_W'(row_reg + 1'b1);
        end else begin
            col_next = COL_W'(col_reg + 1'b1);
            row_next = row_reg;
        end
    end

    assign cur_pos = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);

    // While scrolling, row r+1 is read in the cycle before it is written to row r.
    assign sweep_copy = copy_reg && (cnt_reg < AW'(UPPER));

    assign ram_raddr = (state_reg == ST_SWEEP) ? AW'(cnt_reg + AW'(COLUMNS)) : AW'(in_idx);
    assign ram_we    = pend_reg || (s_fire && is_put && !is_nl);
    assign ram_waddr = pend_reg ? pend_addr_reg : cur_pos;

    always_comb begin
        if (pend_reg) begin
            ram_wdata = pend_blank_reg ? tcw_pkg::BLANK_CELL : ram_rdata;
        end else begin
            ram_wdata = {attr_reg, in_char};
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == tcw_pkg::CFG_ATTR_IDX);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tcw_pkg::CFG_ATTR_IDX) ? {24'b0, attr_reg} : 32'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            copy_reg       <= 1'b0;
            report_reg     <= 1'b0;
            scroll_reg     <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            attr_reg       <= tcw_pkg::ATTR_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            pend_reg <= 1'b0;
            if (cfg_wr) begin
                attr_reg <= pwdata[7:0];
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (in_action)
                            tcw_pkg::ACT_PUT: begin
                                if (need_scroll) begin
                                    col_reg    <= '0;
                                    row_reg    <= ROW_W'(ROWS - 1);
                                    state_reg  <= ST_SWEEP;
                                    cnt_reg    <= '0;
                                    copy_reg   <= 1'b1;
                                    report_reg <= 1'b1;
                                    scroll_reg <= 1'b1;
                                end else begin
                                    col_reg        <= col_next;
                                    row_reg        <= row_next;
                                    m_tvalid_reg   <= 1'b1;
                                    out_col_reg    <= 7'(col_next);
                                    out_row_reg    <= 5'(row_next);
                                    out_scroll_reg <= 1'b0;
                                    out_data_reg   <= '0;
                                end
                            end
                            tcw_pkg::ACT_CLEAR: begin
                                col_reg    <= '0;
                                row_reg    <= ROW_W'(ROWS - 1);
                                state_reg  <= ST_SWEEP;
                                cnt_reg    <= '0;
                                copy_reg   <= 1'b0;
                                report_reg <= 1'b1;
                                scroll_reg <= 1'b0;
                            end
                            tcw_pkg::ACT_READ: begin
                                rng_reg   <= in_rng;
                                state_reg <= ST_READ;
                            end
                            default: begin
                                m_tvalid_reg   <= 1'b1;
                                out_col_reg    <= 7'(col_reg);
                                out_row_reg    <= 5'(row_reg);
                                out_scroll_reg <= 1'b0;
                                out_data_reg   <= '0;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    m_tvalid_reg   <= 1'b1;
                    out_col_reg    <= 7'(col_reg);
                    out_row_reg    <= 5'(row_reg);
                    out_scroll_reg <= 1'b0;
                    out_data_reg   <= rng_reg ? ram_rdata : 16'h0000;
                    state_reg      <= ST_IDLE;
                end
                ST_SWEEP: begin
                    pend_reg       <= 1'b1;
                    pend_addr_reg  <= cnt_reg;
                    pend_blank_reg <= !sweep_copy;
                    if (cnt_reg == AW'(CELLS - 1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        cnt_reg <= AW'(cnt_reg + 1'b1);
                    end
                end
                ST_DONE: begin
                    // The last cell of the sweep is written in this cycle.
                    if (report_reg) begin
                        m_tvalid_reg   <= 1'b1;
                        out_col_reg    <= 7'(col_reg);
                        out_row_reg    <= 5'(row_reg);
                        out_scroll_reg <= scroll_reg;
                        out_data_reg   <= '0;
                    end
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_data_reg, out_scroll_reg, out_row_reg, out_col_reg};

`ifndef ASSERT_OFF
    // A sweep write and a character write never compete for the write port.
    assert property (@(posedge aclk) disable iff (!aresetn) pend_reg |-> !s_fire)
        else $error("sweep write overlaps an accepted request");

    // A put that does not scroll delivers its result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_put && !need_scroll) |=> m_tvalid_reg)
        else $error("put result missing");

    // The cursor stays on the screen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg <= COL_W'(COLUMNS - 1)) && (row_reg <= ROW_W'(ROWS - 1)))
        else $error("cursor off screen");

    // No request is taken in the first cycle after reset; the clearing pass runs.
    assert property (@(posedge aclk) disable iff (!aresetn) !$past(aresetn) |-> !s_tready)
        else $error("request taken before the clearing pass");
`endif

endmodule

// ===== src/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== test/tb_text_console_writer.sv =====
// Self-checking testbench of the text console writer: table-driven and random requests.
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLS   = COLUMNS_DEF;
    localparam int ROWS_N = ROWS_DEF;
    localparam int CELLS  = COLS * ROWS_N;
    localparam int PHASES = 4;
    localparam int PHASE_REQUESTS = 195;
    localparam int DIRECTED_ROWS = 24;

    typedef struct packed {
        action_t     act;
        logic [7:0]  ch;
        logic [10:0] idx;
    } console_request_t;

    typedef struct packed {
        logic [6:0]  col;
        logic [4:0]  row;
        logic        scroll;
        logic [15:0] data;
    } console_result_t;

    typedef struct packed {
        action_t     act;
        logic [7:0]  ch;
        logic [10:0] idx;
        bit          typed;
        logic [6:0]  col;
        logic [4:0]  row;
        logic        scroll;
        logic [15:0] data;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] char_code, [18:8] cell_index, rest zero
    logic [1:0]  s_tuser = '0;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [6:0] cursor_column, [11:7] cursor_row,
                                 // [12] did_scroll, [28:13] cell_data, rest zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the console: screen contents, cursor and attribute.
    logic [15:0] screen_model [0:CELLS-1];
    int          cursor_col = 0;
    int          cursor_row = 0;
    logic [7:0]  attr_model = ATTR_RESET;

    console_result_t pending_results [$];
    bit quiet = 1'b0;
    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int reads_sent = 0;
    int clears_sent = 0;
    int scrolls_seen = 0;

    // Typed-in rows can be read straight off the behavior; the others use the shadow.
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ACT_READ,  8'h00, 11'd0,    1'b1, 7'd0, 5'd0,  1'b0, 16'h0020},
        '{ACT_READ,  8'h00, 11'd1999, 1'b1, 7'd0, 5'd0,  1'b0, 16'h0020},
        '{ACT_READ,  8'h00, 11'd2047, 1'b1, 7'd0, 5'd0,  1'b0, 16'h0000},
        '{ACT_NONE,  8'hFF, 11'h7FF,  1'b1, 7'd0, 5'd0,  1'b0, 16'h0000},
        '{ACT_PUT,   8'h41, 11'd0,    1'b1, 7'd1, 5'd0,  1'b0, 16'h0000},
        '{ACT_READ,  8'h00, 11'd0,    1'b1, 7'd1, 5'd0,  1'b0, 16'h0641},
        '{ACT_PUT,   8'hFF, 11'd0,    1'b1, 7'd2, 5'd0,  1'b0, 16'h0000},
        '{ACT_PUT,   8'h00, 11'd0,    1'b1, 7'd3, 5'd0,  1'b0, 16'h0000},
        '{ACT_READ,  8'h00, 11'd1,    1'b1, 7'd3, 5'd0,  1'b0, 16'h06FF},
        '{ACT_READ,  8'h00, 11'd2,    1'b1, 7'd3, 5'd0,  1'b0, 16'h0600},
        '{ACT_PUT,   8'h0A, 11'd0,    1'b1, 7'd0, 5'd1,  1'b0, 16'h0000},
        '{ACT_PUT,   8'h5A, 11'd0,    1'b1, 7'd1, 5'd1,  1'b0, 16'h0000},
        '{ACT_READ,  8'h00, 11'd80,   1'b1, 7'd1, 5'd1,  1'b0, 16'h065A},
        '{ACT_PUT,   8'h80, 11'd0,    1'b0, 7'd0, 5'd0,  1'b0, 16'h0000},
        '{ACT_PUT,   8'h0B, 11'd0,    1'b0, 7'd0, 5'd0,  1'b0, 16'h0000},
        '{ACT_READ,  8'h00, 11'd81,   1'b0, 7'd0, 5'd0,  1'b0, 16'h0000},
        '{ACT_CLEAR, 8'h00, 11'd0,    1'b1, 7'd0, 5'd24, 1'b0, 16'h0000},
        '{ACT_READ,  8'h00, 11'd80,   1'b1, 7'd0, 5'd24, 1'b0, 16'h0020},
        '{ACT_PUT,   8'h7E, 11'd0,    1'b1, 7'd1, 5'd24, 1'b0, 16'h0000},
        '{ACT_READ,  8'h00, 11'd1920, 1'b1, 7'd1, 5'd24, 1'b0, 16'h067E},
        '{ACT_PUT,   8'h0A, 11'd0,    1'b1, 7'd0, 5'd24, 1'b1, 16'h0000},
        '{ACT_READ,  8'h00, 11'd1840, 1'b1, 7'd0, 5'd24, 1'b0, 16'h067E},
        '{ACT_READ,  8'h00, 11'd1920, 1'b1, 7'd0, 5'd24, 1'b0, 16'h0020},
        '{ACT_NONE,  8'h00, 11'd0,    1'b0, 7'd0, 5'd0,  1'b0, 16'h0000}
    };

    text_console_writer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic bit move_cursor(int col, int row);
        cursor_col = col;
        cursor_row = row;
        if (cursor_row >= ROWS_N) begin
            for (int i = 0; i < (ROWS_N - 1) * COLS; i++)
                screen_model[i] = screen_model[i + COLS];
            for (int i = (ROWS_N - 1) * COLS; i < CELLS; i++)
                screen_model[i] = BLANK_CELL;
            cursor_col = 0;
            cursor_row = ROWS_N - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic console_result_t advance_console(console_request_t req);
        console_result_t res;
        int pos;
        bit scrolled;
        logic [15:0] data;
        scrolled = 1'b0;
        data = '0;
        case (req.act)
            ACT_PUT: begin
                if (req.ch == NEWLINE_CODE) begin
                    scrolled = move_cursor(0, cursor_row + 1);
                end else begin
                    pos = cursor_row * COLS + cursor_col;
                    if (pos < CELLS)
                        screen_model[pos] = {attr_model, req.ch};
                    if (cursor_col >= COLS - 1)
                        scrolled = move_cursor(0, cursor_row + 1);
                    else
                        scrolled = move_cursor(cursor_col + 1, cursor_row);
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen_model[i] = BLANK_CELL;
                cursor_col = 0;
                cursor_row = ROWS_N - 1;
            end
            ACT_READ: begin
                if (req.idx < CELLS)
                    data = screen_model[req.idx];
            end
            default: ;
        endcase
        res.col = cursor_col[6:0];
        res.row = cursor_row[4:0];
        res.scroll = scrolled;
        res.data = data;
        return res;
    endfunction

    // Mostly puts of random bytes or newlines; reads favour the bottom two rows, where the text lives.
    function automatic console_request_t random_request();
        console_request_t req;
        int pick;
        pick = $urandom_range(99);
        req.act = ACT_PUT;
        req.ch = 8'($urandom);
        req.idx = 11'($urandom_range(CELLS - 1));
        if (pick < 10) begin
            req.ch = NEWLINE_CODE;
        end else if (pick < 38) begin
            req.act = ACT_READ;
            if ($urandom_range(9) == 0)
                req.idx = 11'($urandom_range(2047, CELLS));
            else if ($urandom_range(1) == 1)
                req.idx = 11'($urandom_range(CELLS - 1, CELLS - 2 * COLS));
        end else if (pick < 41) begin
            req.act = ACT_CLEAR;
        end else if (pick < 44) begin
            req.act = ACT_NONE;
        end
        return req;
    endfunction

    task automatic send_request(console_request_t req, bit typed, console_result_t typed_res);
        console_result_t res;
        if (!quiet && $urandom_range(99) < 9) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, req.idx, req.ch};
        s_tuser <= req.act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = advance_console(req);
        pending_results.push_back(typed ? typed_res : res);
        requests_sent++;
        if (req.act == ACT_READ) reads_sent++;
        if (req.act == ACT_CLEAR) clears_sent++;
        if (res.scroll) scrolls_seen++;
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Write the attribute register, then read it back.
    task automatic write_attribute(logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {CFG_ATTR_IDX, 2'b00};
        pwdata <= {24'b0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        attr_model = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'b0, value}) begin
            $error("text_attribute: expected %0h, got %0h", value, prdata);
            error_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_monitor
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: m_tdata %0h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_tdata[6:0] !== want.col) begin
                    $error("cursor_column: expected %0d, got %0d", want.col, m_tdata[6:0]);
                    error_count++;
                end
                if (m_tdata[11:7] !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, m_tdata[11:7]);
                    error_count++;
                end
                if (m_tdata[12] !== want.scroll) begin
                    $error("did_scroll: expected %0d, got %0d", want.scroll, m_tdata[12]);
                    error_count++;
                end
                if (m_tdata[28:13] !== want.data) begin
                    $error("cell_data: expected %0h, got %0h", want.data, m_tdata[28:13]);
                    error_count++;
                end
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= 9);
    end

    initial begin
        console_request_t req;
        console_result_t typed_res;
        logic [7:0] phase_attr;
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = BLANK_CELL;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            req = '{directed_rows[r].act, directed_rows[r].ch, directed_rows[r].idx};
            typed_res = '{directed_rows[r].col, directed_rows[r].row,
                          directed_rows[r].scroll, directed_rows[r].data};
            send_request(req, directed_rows[r].typed, typed_res);
        end

        for (int p = 0; p < PHASES; p++) begin
            // The attribute only changes with no request in flight.
            drain_requests();
            case (p)
                0: phase_attr = 8'hFF;
                1: phase_attr = 8'h00;
                default: phase_attr = 8'($urandom_range(254, 1));
            endcase
            write_attribute(phase_attr);
            quiet = (p == 1);
            for (int k = 0; k < PHASE_REQUESTS; k++)
                send_request(random_request(), 1'b0, '0);
        end
        drain_requests();
        quiet = 1'b0;
        repeat (2100) @(posedge aclk);

        $display("Sent %0d requests (%0d reads, %0d clears), %0d of them scrolled the screen.",
                 requests_sent, reads_sent, clears_sent, scrolls_seen);
        $display("Checked %0d results over %0d attribute settings.", results_checked, PHASES + 1);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tcw_pkg.sv
src/tcw_ram.sv
src/text_console_writer.sv
test/tb_text_console_writer.sv
